@@ design/cpu_pkg.sv @@
package cpu_pkg;

	localparam int CODE_WIDTH = 32;
	localparam int ROOT_BITS  = CODE_WIDTH / 2 + 1;
	localparam logic [CODE_WIDTH-1:0] NONTERM_MARK = CODE_WIDTH'(256);

	typedef enum logic [2:0] {
		OP_PAIR2   = 3'd0,
		OP_PAIR3   = 3'd1,
		OP_UNPAIR2 = 3'd2,
		OP_UNPAIR3 = 3'd3,
		OP_CLASS   = 3'd4
	} op_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] operand_a;
		logic [31:0] operand_b;
		logic [31:0] operand_c;
		logic [31:0] code_in;
	} cmd_t;

	typedef struct packed {
		logic [31:0] code_out;
		logic [31:0] first_value;
		logic [31:0] second_value;
		logic [31:0] third_value;
		logic        is_nonterminal;
		logic        overflow;
	} res_t;

	// pair result: code plus overflow flag
	typedef struct packed {
		logic                  ovf;
		logic [CODE_WIDTH-1:0] code;
	} pr_t;

endpackage

@@ design/cpu_pair.sv @@
// Pipelined pairing: sum, triangular product, add b, range check.
module cpu_pair import cpu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  vin,
	input  logic                  ovf_in,
	input  logic [CODE_WIDTH-1:0] a,
	input  logic [CODE_WIDTH-1:0] b,
	output logic                  vout,
	output pr_t                   res
);
	logic                    v_s1, v_s2, v_s3;
	logic [CODE_WIDTH:0]     sum_s1;
	logic [CODE_WIDTH-1:0]   b_s1, b_s2;
	logic                    ovf_s1, ovf_s2;
	logic [2*CODE_WIDTH+1:0] tri_s2;
	pr_t                     res_s3;
	logic [CODE_WIDTH:0]     half_c, odd_c;
	logic [2*CODE_WIDTH+2:0] sum_full;

	// halve the even factor of s(s+1)
	always_comb begin
		if (!sum_s1[0]) begin
			half_c = sum_s1 >> 1;
			odd_c  = sum_s1 + 1'b1;
		end else begin
			half_c = (sum_s1 >> 1) + 1'b1;
			odd_c  = sum_s1;
		end
		sum_full = {1'b0, tri_s2} + {{(CODE_WIDTH+3){1'b0}}, b_s2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= vin;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		sum_s1 <= {1'b0, a} + {1'b0, b};
		b_s1   <= b;
		ovf_s1 <= ovf_in;
		tri_s2 <= (2*CODE_WIDTH+2)'(half_c * odd_c);
		b_s2   <= b_s1;
		ovf_s2 <= ovf_s1;
		res_s3.ovf  <= ovf_s2 || (|sum_full[2*CODE_WIDTH+2:CODE_WIDTH]);
		res_s3.code <= (ovf_s2 || (|sum_full[2*CODE_WIDTH+2:CODE_WIDTH])) ?
			'0 : sum_full[CODE_WIDTH-1:0];
	end

	assign vout = v_s3;
	assign res  = res_s3;
endmodule

@@ design/cpu_unpair.sv @@
// Pipelined unpair: one root bit per stage, then y = z - t, x = w - y.
module cpu_unpair import cpu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  vin,
	input  logic [CODE_WIDTH-1:0] z,
	output logic                  vout,
	output logic [CODE_WIDTH-1:0] x,
	output logic [CODE_WIDTH-1:0] y
);
	localparam int NS = ROOT_BITS;
	localparam int TW = 2*ROOT_BITS + 1;

	logic [NS:0]                v_q;
	logic [NS:0][CODE_WIDTH-1:0] z_q;
	logic [NS:0][ROOT_BITS-1:0]  w_q;
	logic [NS:0][TW-1:0]         t_q;
	logic                        vo_q;
	logic [CODE_WIDTH-1:0]       x_q, y_q, yc;

	assign v_q[0] = vin;
	assign z_q[0] = z;
	assign w_q[0] = '0;
	assign t_q[0] = '0;

	// each stage tries one root bit: T(w+d) = T(w) + d*w + d(d+1)/2
	for (genvar k = 0; k < NS; k++) begin : g_bit
		localparam int B = NS - 1 - k;
		logic [TW-1:0] tc;
		always_comb begin
			tc = t_q[k] + (TW'(w_q[k]) << B) +
				((TW'(1) << (2*B)) + (TW'(1) << B)) / 2;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q[k+1] <= 1'b0;
			else         v_q[k+1] <= v_q[k];
		end
		always_ff @(posedge clk) begin
			z_q[k+1] <= z_q[k];
			if (tc <= TW'(z_q[k])) begin
				w_q[k+1] <= w_q[k] | (ROOT_BITS'(1) << B);
				t_q[k+1] <= tc;
			end else begin
				w_q[k+1] <= w_q[k];
				t_q[k+1] <= t_q[k];
			end
		end
	end

	assign yc = z_q[NS] - t_q[NS][CODE_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vo_q <= 1'b0;
		else         vo_q <= v_q[NS];
	end
	always_ff @(posedge clk) begin
		y_q <= yc;
		x_q <= CODE_WIDTH'(w_q[NS]) - yc;
	end

	assign vout = vo_q;
	assign x = x_q;
	assign y = y_q;
endmodule

@@ design/cantor_pair_unpair_unit_top.sv @@
// Channel   Ports                    Handshake
// command   cmd (cmd_t)              start high, busy low
// result    res (res_t)              done strobe, one cycle, no stall
//
// One word enters per cycle; busy is always low.
// Each word passes through two root pipelines (17 root-bit stages plus an
// output register each) and a result register; pair words wait in a
// delay line so results stay in order.
// Reset clears valid bits only; in-flight words are dropped.
// The receiver cannot stall; each word is delivered once.
module cantor_pair_unpair_unit_top import cpu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output res_t res
);
	localparam int PL = 3;
	localparam int UL = ROOT_BITS + 1;
	localparam int DL = 2*UL + 1;

	// delay line for opcode and operand c
	logic [DL-1:0]          dv_q;
	logic [DL-1:0][2:0]     dop_q;
	logic [PL:0][31:0]      dc_q;
	logic [CODE_WIDTH-1:0]  a_in, b_in, c_in, z_in;

	assign a_in = CODE_WIDTH'(cmd.operand_a);
	assign b_in = CODE_WIDTH'(cmd.operand_b);
	assign c_in = CODE_WIDTH'(cmd.operand_c);
	assign z_in = CODE_WIDTH'(cmd.code_in);
	assign busy = 1'b0;
	assign dv_q[0]  = start;
	assign dop_q[0] = cmd.opcode;
	assign dc_q[0]  = cmd.operand_c;

	for (genvar k = 0; k < DL-1; k++) begin : g_dly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_q[k+1] <= 1'b0;
			else         dv_q[k+1] <= dv_q[k];
		end
		always_ff @(posedge clk) begin
			dop_q[k+1] <= dop_q[k];
		end
	end

	// hold operand c until the second pair pass
	for (genvar k = 0; k < PL; k++) begin : g_cdly
		always_ff @(posedge clk) begin
			dc_q[k+1] <= dc_q[k];
		end
	end

	// first pair pass, second pair pass
	logic pv1, pv2, uv1, uv2;
	pr_t  p1, p2;
	cpu_pair u_p1 (.clk, .arst_n, .vin(start), .ovf_in(1'b0),
		.a(a_in), .b(b_in), .vout(pv1), .res(p1));
	cpu_pair u_p2 (.clk, .arst_n, .vin(pv1), .ovf_in(p1.ovf),
		.a(p1.code), .b(CODE_WIDTH'(dc_q[PL])), .vout(pv2), .res(p2));

	// first unpair, second unpair of x
	logic [CODE_WIDTH-1:0] x1, y1, x2, y2;
	logic [CODE_WIDTH-1:0] y1_q [UL];
	cpu_unpair u_u1 (.clk, .arst_n, .vin(start), .z(z_in),
		.vout(uv1), .x(x1), .y(y1));
	cpu_unpair u_u2 (.clk, .arst_n, .vin(uv1), .z(x1),
		.vout(uv2), .x(x2), .y(y2));

	// hold x1, y1 and pair results until the final stage
	pr_t p1d_q [2*UL-PL];
	pr_t p2d_q [2*UL-2*PL];
	logic [CODE_WIDTH-1:0] x1_q [UL];
	logic [CODE_WIDTH-1:0] y1d_q [UL];
	always_ff @(posedge clk) begin
		p1d_q[0] <= p1;
		p2d_q[0] <= p2;
		x1_q[0]  <= x1;
		y1d_q[0] <= y1;
		for (int i = 1; i < 2*UL-PL; i++) p1d_q[i] <= p1d_q[i-1];
		for (int i = 1; i < 2*UL-2*PL; i++) p2d_q[i] <= p2d_q[i-1];
		for (int i = 1; i < UL; i++) begin
			x1_q[i]  <= x1_q[i-1];
			y1d_q[i] <= y1d_q[i-1];
		end
		y1_q[0] <= y1;
		for (int i = 1; i < UL; i++) y1_q[i] <= y1_q[i-1];
	end

	// assemble result at stage DL
	res_t r_c, r_q;
	logic d_q;
	logic [CODE_WIDTH-1:0] fx, fy;
	always_comb begin
		r_c = '0;
		fx = x1_q[UL-1];
		fy = y1d_q[UL-1];
		case (dop_q[DL-1])
			OP_PAIR2: begin
				r_c.code_out = 32'(p1d_q[2*UL-PL-1].code);
				r_c.overflow = p1d_q[2*UL-PL-1].ovf;
			end
			OP_PAIR3: begin
				r_c.code_out = 32'(p2d_q[2*UL-2*PL-1].code);
				r_c.overflow = p2d_q[2*UL-2*PL-1].ovf;
			end
			OP_UNPAIR2: begin
				r_c.first_value  = 32'(fx);
				r_c.second_value = 32'(fy);
			end
			OP_UNPAIR3: begin
				r_c.first_value  = 32'(x2);
				r_c.second_value = 32'(y2);
				r_c.third_value  = 32'(y1_q[UL-1]);
			end
			OP_CLASS: begin
				r_c.first_value    = 32'(fx);
				r_c.second_value   = 32'(fy);
				r_c.is_nonterminal = (fy == NONTERM_MARK);
				r_c.code_out = (fy == NONTERM_MARK) ? 32'(fx) : 32'hFFFF_FFFF;
			end
			default: r_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) d_q <= 1'b0;
		else         d_q <= dv_q[DL-1] & (uv2 | ~uv2) & (pv2 | ~pv2);
	end
	always_ff @(posedge clk) r_q <= r_c;

	assign done = d_q;
	assign res  = r_q;
endmodule
